// ===== design/lrf_pkg.sv =====
package lrf_pkg;

    // Batch size limit; sample count, sum and denominator widths all follow from it.
    localparam int MAX_SAMPLES = 1024;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

    localparam int XW     = 20;                       // Q12.8 sample fields
    localparam int SUM_W  = XW + CNT_W;               // sum of x, sum of y
    localparam int SQ_W   = 2 * XW + CNT_W;           // sum of x*x, sum of x*y
    localparam int DEN_W  = 2 * CNT_W + 2 * XW - 2;   // |numerator| and denominator
    localparam int MUL_W  = 33;                       // shared multiplier operands
    localparam int PROD_W = 2 * MUL_W;
    localparam int SPLIT  = 26;                       // low part of a wide sum operand
    localparam int COEF_W = 32;                       // Q16.16 coefficients
    localparam int FRAC   = 16;
    localparam int PRED_W = 20;                       // Q12.8 prediction
    localparam int QUOT_W = 32;
    localparam int DIV_CNT_W = $clog2(QUOT_W + 1);

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_DEGEN = 2'd1;
    localparam t_status ST_SAT   = 2'd2;

    localparam logic REQ_QUERY = 1'b1;
    localparam logic RK_COEF   = 1'b0;
    localparam logic RK_PRED   = 1'b1;

    typedef enum logic [1:0] {
        KIND_SAMPLE,
        KIND_LAST,
        KIND_QUERY
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic signed [XW-1:0]  x;
        logic signed [XW-1:0]  y;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

    typedef struct packed {
        logic              start;
        logic [DEN_W-1:0]  rem0;
        logic [QUOT_W-1:0] low;
        logic [DEN_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic                     kind;
        logic signed [COEF_W-1:0] intercept;
        logic signed [COEF_W-1:0] slope;
        logic signed [PRED_W-1:0] prediction;
        t_status                  status;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRED,
        S_WAIT,
        S_CHECK,
        S_MUL,
        S_ACC,
        S_DEN,
        S_SDIV,
        S_IMUL,
        S_ISUB,
        S_IDIV0,
        S_IDIV,
        S_RESULT
    } t_state;

    typedef enum logic [2:0] {
        M_NXX_LO,
        M_NXX_HI,
        M_SXSX,
        M_NXY_LO,
        M_NXY_HI,
        M_SXSY
    } t_mstep;

endpackage

// ===== design/lrf_front.sv =====
module lrf_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_req_type,
    input  logic                      i_last,
    input  logic [2*lrf_pkg::XW-1:0]  i_data,
    output lrf_pkg::t_q_head          o_head,
    input  logic                      i_pop
);
    import lrf_pkg::*;

    t_item           r_q [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;
    t_item           in_item;
    logic            push;

    // Classify the beat: a query ignores its last mark.
    always_comb begin
        in_item.x = $signed(i_data[XW-1:0]);
        in_item.y = $signed(i_data[2*XW-1:XW]);
        if (i_req_type == REQ_QUERY) begin
            in_item.kind = KIND_QUERY;
        end else if (i_last) begin
            in_item.kind = KIND_LAST;
        end else begin
            in_item.kind = KIND_SAMPLE;
        end
    end

    assign o_ready     = (r_cnt != (Q_AW + 1)'(Q_DEPTH));
    assign push        = i_valid && o_ready;
    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== design/lrf_div.sv =====
module lrf_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lrf_pkg::t_div_req i_req,
    output lrf_pkg::t_div_rsp o_rsp
);
    import lrf_pkg::*;

    logic [DEN_W-1:0]     r_rem;
    logic [QUOT_W-1:0]    r_low;
    logic [DEN_W-1:0]     r_div;
    logic [QUOT_W-1:0]    r_q;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] n_rem;

    // One restoring step: the remainder stays below the divisor throughout.
    always_comb begin
        trial = {r_rem, r_low[QUOT_W-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
        n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(QUOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem0;
            r_low <= i_req.low;
            r_div <= i_req.divisor;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_low <= {r_low[QUOT_W-2:0], 1'b0};
            r_q   <= {r_q[QUOT_W-2:0], ge};
        end
    end

endmodule

// ===== design/lrf_back.sv =====
module lrf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lrf_pkg::t_q_head  i_head,
    output logic              o_pop,
    output lrf_pkg::t_div_req o_div_req,
    input  lrf_pkg::t_div_rsp i_div_rsp,
    output logic              o_valid,
    input  logic              i_ready,
    output lrf_pkg::t_result  o_result
);
    import lrf_pkg::*;

    localparam logic signed [PROD_W-1:0] PRED_HI  = PROD_W'((1 << (PRED_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0] PRED_LO  = -PRED_HI - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] RND_BIAS = PROD_W'((1 << FRAC) - 1);
    localparam int                       PRED_SH  = 8;

    // Returns {saturated, signed value} for a magnitude and its sign.
    function automatic logic [COEF_W:0] clamp_coef(input logic neg,
                                                   input logic [QUOT_W-1:0] mag);
        logic [COEF_W:0]   lim;
        logic [COEF_W-1:0] m;
        logic              sat;
        lim = neg ? ((COEF_W + 1)'(1) << (COEF_W - 1))
                  : (((COEF_W + 1)'(1) << (COEF_W - 1)) - (COEF_W + 1)'(1));
        sat = ({1'b0, mag} > lim);
        m   = sat ? lim[COEF_W-1:0] : mag;
        return {sat, (neg ? -m : m)};
    endfunction

    t_state r_state;
    t_state n_state;
    t_mstep r_step;

    logic [CNT_W-1:0]         r_count;
    logic signed [SUM_W-1:0]  r_sx;
    logic signed [SUM_W-1:0]  r_sy;
    logic signed [SQ_W-1:0]   r_sxx;
    logic signed [SQ_W-1:0]   r_sxy;
    logic                     r_acc_en;
    logic signed [XW-1:0]     r_ax;
    logic signed [XW-1:0]     r_ay;
    logic signed [2*XW-1:0]   r_axx;
    logic signed [2*XW-1:0]   r_axy;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_num;
    logic signed [PROD_W-1:0] r_den;
    logic signed [PROD_W-1:0] r_t;
    logic signed [COEF_W-1:0] r_w_slope;
    logic signed [COEF_W-1:0] r_w_icpt;
    logic                     r_neg;
    logic                     r_sat;
    logic                     r_degen;

    logic signed [COEF_W-1:0] r_fit_slope;
    logic signed [COEF_W-1:0] r_fit_icpt;
    logic                     r_fit_valid;

    logic                     r_ovalid;
    t_result                  r_out;

    // Control decode
    logic                     out_free;
    logic                     take;
    logic                     take_smp;
    logic                     room;
    logic                     prod_en;
    logic                     out_load;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;

    // Fit arithmetic
    logic                     den_le0;
    logic                     num_neg;
    logic [PROD_W-1:0]        num_abs;
    logic [DEN_W-1:0]         an;
    logic [DEN_W-1:0]         dv;
    logic                     slope_ovf;
    logic                     t_neg;
    logic [PROD_W-1:0]        t_abs;
    logic [PROD_W-1:0]        at;
    logic                     icpt_ovf;
    logic [COEF_W:0]          div_clamp;
    logic [COEF_W:0]          ovf_clamp_s;
    logic [COEF_W:0]          ovf_clamp_i;

    // Prediction arithmetic
    logic signed [PROD_W-1:0] p_sum;
    logic signed [PROD_W-1:0] p_div;
    logic                     p_sat;
    logic signed [PRED_W-1:0] p_val;

    assign out_free = !r_ovalid || i_ready;
    assign room     = (r_count < CNT_W'(MAX_SAMPLES));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    if (i_head.item.kind == KIND_QUERY) begin
                        n_state = S_PRED;
                    end else if (i_head.item.kind == KIND_LAST) begin
                        n_state = S_WAIT;
                    end
                end
            end
            S_PRED: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_WAIT:  n_state = S_CHECK;
            S_CHECK: n_state = (r_count < CNT_W'(2)) ? S_RESULT : S_MUL;
            S_MUL:   n_state = S_ACC;
            S_ACC:   n_state = (r_step == M_SXSY) ? S_DEN : S_MUL;
            S_DEN: begin
                if (den_le0) begin
                    n_state = S_RESULT;
                end else if (slope_ovf) begin
                    n_state = S_IMUL;
                end else begin
                    n_state = S_SDIV;
                end
            end
            S_SDIV: begin
                if (i_div_rsp.done) begin
                    n_state = S_IMUL;
                end
            end
            S_IMUL:  n_state = S_ISUB;
            S_ISUB:  n_state = S_IDIV0;
            S_IDIV0: n_state = icpt_ovf ? S_RESULT : S_IDIV;
            S_IDIV: begin
                if (i_div_rsp.done) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        take      = (r_state == S_IDLE) && i_head.valid;
        take_smp  = take && (i_head.item.kind != KIND_QUERY);
        prod_en   = 1'b0;
        out_load  = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        o_div_req = '0;
        case (r_state)
            S_IDLE: begin
                mul_a   = MUL_W'(r_fit_slope);
                mul_b   = MUL_W'(i_head.item.x);
                prod_en = take;
            end
            S_MUL: begin
                prod_en = 1'b1;
                case (r_step)
                    M_NXX_LO: begin
                        mul_a = MUL_W'(r_count);
                        mul_b = MUL_W'(r_sxx[SPLIT-1:0]);
                    end
                    M_NXX_HI: begin
                        mul_a = MUL_W'(r_count);
                        mul_b = MUL_W'($signed(r_sxx[SQ_W-1:SPLIT]));
                    end
                    M_SXSX: begin
                        mul_a = MUL_W'(r_sx);
                        mul_b = MUL_W'(r_sx);
                    end
                    M_NXY_LO: begin
                        mul_a = MUL_W'(r_count);
                        mul_b = MUL_W'(r_sxy[SPLIT-1:0]);
                    end
                    M_NXY_HI: begin
                        mul_a = MUL_W'(r_count);
                        mul_b = MUL_W'($signed(r_sxy[SQ_W-1:SPLIT]));
                    end
                    M_SXSY: begin
                        mul_a = MUL_W'(r_sx);
                        mul_b = MUL_W'(r_sy);
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            S_DEN: begin
                o_div_req.start   = !den_le0 && !slope_ovf;
                o_div_req.rem0    = an >> FRAC;
                o_div_req.low     = {an[FRAC-1:0], FRAC'(0)};
                o_div_req.divisor = dv;
            end
            S_IMUL: begin
                mul_a   = MUL_W'(r_w_slope);
                mul_b   = MUL_W'(r_sx);
                prod_en = 1'b1;
            end
            S_IDIV0: begin
                o_div_req.start   = !icpt_ovf;
                o_div_req.rem0    = DEN_W'(at >> QUOT_W);
                o_div_req.low     = at[QUOT_W-1:0];
                o_div_req.divisor = DEN_W'(r_count);
            end
            S_PRED, S_RESULT: out_load = out_free;
            default: begin
                prod_en = 1'b0;
            end
        endcase
    end

    assign o_pop = take;
    assign prod  = mul_a * mul_b;

    // Fit arithmetic on the registered sums
    always_comb begin
        den_le0     = r_den[PROD_W-1] || (r_den == '0);
        num_neg     = r_num[PROD_W-1];
        num_abs     = num_neg ? PROD_W'(-r_num) : PROD_W'(r_num);
        an          = num_abs[DEN_W-1:0];
        dv          = r_den[DEN_W-1:0];
        slope_ovf   = ((an >> FRAC) >= dv);
        t_neg       = r_t[PROD_W-1];
        t_abs       = t_neg ? PROD_W'(-r_t) : PROD_W'(r_t);
        at          = t_abs >> PRED_SH;
        icpt_ovf    = ((at >> QUOT_W) >= PROD_W'(r_count));
        div_clamp   = clamp_coef(r_neg, i_div_rsp.quot);
        ovf_clamp_s = clamp_coef(num_neg, '1);
        ovf_clamp_i = clamp_coef(t_neg, '1);
    end

    // Prediction: truncate toward zero, then clamp to the Q12.8 range
    always_comb begin
        p_sum = (PROD_W'(r_fit_icpt) <<< PRED_SH) + r_prod;
        p_div = p_sum[PROD_W-1] ? ((p_sum + RND_BIAS) >>> FRAC) : (p_sum >>> FRAC);
        p_sat = (p_div > PRED_HI) || (p_div < PRED_LO);
        if (p_div > PRED_HI) begin
            p_val = PRED_HI[PRED_W-1:0];
        end else if (p_div < PRED_LO) begin
            p_val = PRED_LO[PRED_W-1:0];
        end else begin
            p_val = p_div[PRED_W-1:0];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= M_NXX_LO;
            r_count     <= '0;
            r_sx        <= '0;
            r_sy        <= '0;
            r_sxx       <= '0;
            r_sxy       <= '0;
            r_acc_en    <= 1'b0;
            r_fit_slope <= '0;
            r_fit_icpt  <= '0;
            r_fit_valid <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_acc_en <= take_smp && room;

            if (r_state == S_CHECK) begin
                r_step <= M_NXX_LO;
            end else if (r_state == S_ACC) begin
                r_step <= t_mstep'(r_step + 1'b1);
            end

            if ((r_state == S_RESULT) && out_free) begin
                r_count     <= '0;
                r_sx        <= '0;
                r_sy        <= '0;
                r_sxx       <= '0;
                r_sxy       <= '0;
                r_fit_slope <= r_w_slope;
                r_fit_icpt  <= r_w_icpt;
                r_fit_valid <= !r_degen;
            end else begin
                if (take_smp && room) begin
                    r_count <= r_count + 1'b1;
                end
                if (r_acc_en) begin
                    r_sx  <= r_sx + SUM_W'(r_ax);
                    r_sy  <= r_sy + SUM_W'(r_ay);
                    r_sxx <= r_sxx + SQ_W'(r_axx);
                    r_sxy <= r_sxy + SQ_W'(r_axy);
                end
            end

            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (take_smp) begin
            r_ax  <= i_head.item.x;
            r_ay  <= i_head.item.y;
            r_axx <= i_head.item.x * i_head.item.x;
            r_axy <= i_head.item.x * i_head.item.y;
        end
        if (prod_en) begin
            r_prod <= prod;
        end
        case (r_state)
            S_CHECK: begin
                r_num     <= '0;
                r_den     <= '0;
                r_w_slope <= '0;
                r_w_icpt  <= '0;
                r_sat     <= 1'b0;
                r_degen   <= (r_count < CNT_W'(2));
            end
            S_ACC: begin
                case (r_step)
                    M_NXX_LO: r_den <= r_den + r_prod;
                    M_NXX_HI: r_den <= r_den + (r_prod <<< SPLIT);
                    M_SXSX:   r_den <= r_den - r_prod;
                    M_NXY_LO: r_num <= r_num + r_prod;
                    M_NXY_HI: r_num <= r_num + (r_prod <<< SPLIT);
                    M_SXSY:   r_num <= r_num - r_prod;
                    default:  r_num <= r_num;
                endcase
            end
            S_DEN: begin
                r_neg <= num_neg;
                if (den_le0) begin
                    r_degen <= 1'b1;
                end else if (slope_ovf) begin
                    r_w_slope <= ovf_clamp_s[COEF_W-1:0];
                    r_sat     <= 1'b1;
                end
            end
            S_SDIV: begin
                if (i_div_rsp.done) begin
                    r_w_slope <= div_clamp[COEF_W-1:0];
                    r_sat     <= r_sat | div_clamp[COEF_W];
                end
            end
            S_ISUB: begin
                r_t <= (PROD_W'(r_sy) <<< FRAC) - r_prod;
            end
            S_IDIV0: begin
                r_neg <= t_neg;
                if (icpt_ovf) begin
                    r_w_icpt <= ovf_clamp_i[COEF_W-1:0];
                    r_sat    <= 1'b1;
                end
            end
            S_IDIV: begin
                if (i_div_rsp.done) begin
                    r_w_icpt <= div_clamp[COEF_W-1:0];
                    r_sat    <= r_sat | div_clamp[COEF_W];
                end
            end
            default: begin
                r_neg <= r_neg;
            end
        endcase

        if (out_load) begin
            if (r_state == S_PRED) begin
                r_out.kind       <= RK_PRED;
                r_out.intercept  <= r_fit_icpt;
                r_out.slope      <= r_fit_slope;
                r_out.prediction <= r_fit_valid ? p_val : '0;
                r_out.status     <= !r_fit_valid ? ST_DEGEN : (p_sat ? ST_SAT : ST_OK);
            end else begin
                r_out.kind       <= RK_COEF;
                r_out.intercept  <= r_w_icpt;
                r_out.slope      <= r_w_slope;
                r_out.prediction <= '0;
                r_out.status     <= r_degen ? ST_DEGEN : (r_sat ? ST_SAT : ST_OK);
            end
        end
    end

    assign o_valid  = r_ovalid;
    assign o_result = r_out;

endmodule

// ===== design/linear_regression_fit_predict_core.sv =====
// Least-squares straight-line fit with prediction queries.
//
// Input stream (s_axis): tdata carries x_value then y_value (signed Q12.8), tuser is
// the request type (training sample or prediction query) and tlast marks the last
// training sample of a batch. Beats land in a four-entry queue, so the input side
// keeps accepting up to four beats while the fit engine is busy or the output stalls.
// Output stream (m_axis): tuser is the result kind (coefficients or prediction) and
// tdata carries intercept, slope (Q16.16), prediction (Q12.8) and status.
//
// Throughput: while the engine is idle, a training sample leaves the queue every
// cycle; its products are registered and summed in the following cycle. A query
// passes through the engine as one registered multiply, then add, round and clamp
// into the result register, which holds it while the output stalls. The closing
// sample of a batch starts the fit: six passes through the shared 33 x 33 multiplier
// form the numerator and denominator, then up to two runs of the radix-2 divider
// (32 steps each) produce slope and intercept; the coefficient beat then goes to
// the result register.
// Reset clears the sums, the stored fit, the queue and the output valid flag; a query
// before any fit answers with status degenerate. On an output stall the one result
// register holds its beat, the engine waits at its next result and the queue fills up.
module linear_regression_fit_predict_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // [19:0] x_value, [39:20] y_value
    input  logic        i_s_axis_tuser,   // [0] req_type
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [87:0] o_m_axis_tdata,   // [31:0] intercept, [63:32] slope,
                                          // [83:64] prediction, [85:84] status, rest zero
    output logic        o_m_axis_tuser    // [0] result_kind
);
    import lrf_pkg::*;

    t_q_head  q_head;
    logic     q_pop;
    t_div_req div_req;
    t_div_rsp div_rsp;
    t_result  result;

    lrf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_req_type (i_s_axis_tuser),
        .i_last     (i_s_axis_tlast),
        .i_data     (i_s_axis_tdata),
        .o_head     (q_head),
        .i_pop      (q_pop)
    );

    lrf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    lrf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (q_head),
        .o_pop     (q_pop),
        .o_div_req (div_req),
        .i_div_rsp (div_rsp),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_result  (result)
    );

    assign o_m_axis_tuser = result.kind;
    assign o_m_axis_tdata = {2'b00, result.status, result.prediction,
                             result.slope, result.intercept};

    // The engine only takes an item that the queue actually holds.
    a_pop_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_head.valid)
        else $error("engine popped an empty queue");

    // Back-pressure on the input only ever comes from a full queue.
    a_full_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> q_head.valid)
        else $error("input stalled with an empty queue");

    // A division never finishes the cycle after it was started.
    a_div_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> !div_rsp.done)
        else $error("divider finished too early");

    // No new division is launched while one reports its quotient.
    a_div_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> !div_req.start)
        else $error("divider restarted while delivering");

endmodule

// ===== tb/tb_linear_regression_fit_predict_core.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the least-squares line fitter. An initial block queues
// sample and query beats; a clocked driver offers them on the input stream with
// random gaps, and every accepted beat is folded into a behavioural copy of the
// fitter held here. A clocked receiver, also with random stalls, compares each
// output beat field by field against the oldest result still due.
module tb_linear_regression_fit_predict_core;
    import lrf_pkg::*;

    localparam logic   REQ_SAMPLE    = 1'b0;
    localparam int     RANDOM_BEATS  = 80;
    localparam int     LONG_HOLD     = 400;     // receiver hold-off, in cycles
    localparam int     SETTLE_CYCLES = 120;     // wait after the final drain before the last check
    localparam longint Q12_MIN = -(longint'(1) <<< 19);
    localparam longint Q12_MAX = (longint'(1) <<< 19) - 1;
    localparam longint Q16_MIN = -(longint'(1) <<< 31);
    localparam longint Q16_MAX = (longint'(1) <<< 31) - 1;

    // One input beat as the stimulus sees it.
    typedef struct {
        logic                 req;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic                 last;
    } t_beat;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [39:0] s_tdata  = '0;   // [19:0] x_value, [39:20] y_value
    logic        s_tuser  = 1'b0; // [0] req_type
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [87:0] m_tdata;         // [31:0] intercept, [63:32] slope, [83:64] prediction,
                                  // [85:84] status
    wire         m_tuser;         // [0] result_kind

    linear_regression_fit_predict_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stimulus bookkeeping.
    t_beat   beats_to_send[$];
    t_result results_due[$];
    t_beat   cur_beat;
    int      beats_queued = 0;
    int      beats_sent   = 0;
    int      results_seen = 0;
    int      mismatches   = 0;
    int      src_idle     = 0;
    int      src_calm     = 0;
    int      sink_idle    = 0;
    int      sink_calm    = 0;
    bit      hold_req     = 1'b0;

    // Behavioural copy of the fitter: running sums and the stored fit.
    longint  acc_n  = 0;
    longint  acc_x  = 0;
    longint  acc_y  = 0;
    longint  acc_xx = 0;
    longint  acc_xy = 0;
    longint  fit_b0 = 0;     // intercept, Q16.16
    longint  fit_b1 = 0;     // slope, Q16.16
    bit      fit_ok = 1'b0;

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi,
                                        inout bit sat);
        if (v < lo) begin
            sat = 1'b1;
            return lo;
        end
        if (v > hi) begin
            sat = 1'b1;
            return hi;
        end
        return v;
    endfunction

    // Closes a batch: solves for slope and intercept from the sums and replaces
    // the stored fit. A batch with fewer than two samples or with no spread in x
    // leaves no valid fit at all.
    function automatic t_status solve_line_fit();
        longint       n;
        longint       num;
        longint       den;
        logic [127:0] mag;
        logic [127:0] lim;
        bit           neg;
        bit           sat;
        n      = acc_n;
        sat    = 1'b0;
        fit_b0 = 0;
        fit_b1 = 0;
        fit_ok = 1'b0;
        if (n < 2)
            return ST_DEGEN;
        den = n * acc_xx - acc_x * acc_x;
        if (den <= 0)
            return ST_DEGEN;
        num = n * acc_xy - acc_x * acc_y;
        neg = num < 0;
        mag = neg ? 128'(-num) : 128'(num);
        // Magnitude of the quotient, truncated to 16 fraction bits, then limited
        // to what a signed 32-bit field can hold on that side of zero.
        mag = (mag << 16) / 128'(den);
        lim = neg ? 128'(64'h8000_0000) : 128'(64'h7fff_ffff);
        if (mag > lim) begin
            mag = lim;
            sat = 1'b1;
        end
        fit_b1 = neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
        fit_b0 = clamp_to((acc_y * 65536 - fit_b1 * acc_x) / (256 * n), Q16_MIN, Q16_MAX,
                          sat);
        fit_ok = 1'b1;
        return sat ? ST_SAT : ST_OK;
    endfunction

    // Folds one accepted beat into the model and queues the result it causes.
    task automatic track_regression(input t_beat b);
        longint  x;
        longint  y;
        t_result r;
        bit      sat;
        x   = b.x;
        y   = b.y;
        sat = 1'b0;
        r   = '0;
        if (b.req == REQ_SAMPLE) begin
            // Samples past the batch limit are dropped, but a last mark still closes it.
            if (acc_n < MAX_SAMPLES) begin
                acc_n++;
                acc_x  += x;
                acc_y  += y;
                acc_xx += x * x;
                acc_xy += x * y;
            end
            if (!b.last)
                return;
            r.kind   = RK_COEF;
            r.status = solve_line_fit();
            acc_n  = 0;
            acc_x  = 0;
            acc_y  = 0;
            acc_xx = 0;
            acc_xy = 0;
        end else begin
            // A query ignores y and its last mark, and carries the current fit along.
            r.kind = RK_PRED;
            if (!fit_ok) begin
                r.status = ST_DEGEN;
            end else begin
                r.prediction = PRED_W'(clamp_to((fit_b0 * 256 + fit_b1 * x) / 65536,
                                                Q12_MIN, Q12_MAX, sat));
                r.status = sat ? ST_SAT : ST_OK;
            end
        end
        r.intercept = fit_b0[31:0];
        r.slope     = fit_b1[31:0];
        results_due.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic signed [63:0] got,
                                   input logic signed [63:0] want);
        mismatches++;
        $display("mismatch in %s at output beat %0d: got %0d, expected %0d",
                 what, results_seen, got, want);
    endtask

    task automatic check_result();
        t_result got;
        t_result want;
        got = {m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[83:64], m_tdata[85:84]};
        results_seen++;
        if (results_due.size() == 0) begin
            report_mismatch("result_kind (no result due)", got.kind, 0);
            return;
        end
        want = results_due.pop_front();
        if (got.kind !== want.kind)
            report_mismatch("result_kind", got.kind, want.kind);
        if (got.intercept !== want.intercept)
            report_mismatch("intercept", got.intercept, want.intercept);
        if (got.slope !== want.slope)
            report_mismatch("slope", got.slope, want.slope);
        if (got.prediction !== want.prediction)
            report_mismatch("prediction", got.prediction, want.prediction);
        if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
    endtask

    // Gap length after a beat: mostly none or short, now and then long, and
    // occasionally a calm stretch of beats with no gaps at all.
    function automatic int idle_len(inout int calm_left);
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Input driver: a beat stays on the bus until it is taken, then the next one
    // follows after a random gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                track_regression(cur_beat);
                beats_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_idle > 0) begin
                    src_idle--;
                    s_tvalid <= 1'b0;
                end else if (beats_to_send.size() > 0) begin
                    cur_beat = beats_to_send.pop_front();
                    s_tdata  <= {cur_beat.y, cur_beat.x};
                    s_tuser  <= cur_beat.req;
                    s_tlast  <= cur_beat.last;
                    s_tvalid <= 1'b1;
                    src_idle = idle_len(src_calm);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output receiver: checks each beat taken and stalls at random, or for one
    // long stretch when the stimulus asks for it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result();
                sink_idle = idle_len(sink_calm);
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                sink_idle = LONG_HOLD;
            end
            if (sink_idle > 0) begin
                sink_idle--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic longint random_x();
        logic signed [XW-1:0] v;
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0: return Q12_MIN;
                1: return Q12_MAX;
                2: return 0;
                default: return -1;
            endcase
        end
        v = XW'($urandom);
        return longint'(v);
    endfunction

    function automatic longint rand_span(input int amp);
        return longint'($urandom_range(0, 2 * amp)) - amp;
    endfunction

    task automatic push_beat(input logic req, input longint x, input longint y,
                             input logic last);
        t_beat b;
        bit    dummy;
        dummy  = 1'b0;
        b.req  = req;
        b.x    = XW'(clamp_to(x, Q12_MIN, Q12_MAX, dummy));
        b.y    = XW'(clamp_to(y, Q12_MIN, Q12_MAX, dummy));
        b.last = last;
        beats_to_send.push_back(b);
        beats_queued++;
    endtask

    // A batch of samples lying near a random line, with the last one marked.
    // A steep batch squeezes x into a tight cluster under free y, which drives
    // the slope and intercept into saturation.
    task automatic queue_fit_batch(input int len, input bit steep);
        int     spread;
        int     kshift;
        int     noise;
        int     i;
        longint centre;
        longint k;
        longint ofs;
        longint xv;
        longint yv;
        bit     free_y;
        case ($urandom_range(0, 3))
            0: spread = 0;
            1: spread = 4096;
            2: spread = 256;
            default: spread = -1;
        endcase
        if (steep)
            spread = -1;
        centre = random_x() >>> $urandom_range(0, 8);
        k      = longint'($urandom_range(0, 4096)) - 2048;
        kshift = $urandom_range(0, 14);
        ofs    = random_x() >>> $urandom_range(0, 19);
        noise  = 1 << $urandom_range(0, 12);
        free_y = steep || ($urandom_range(0, 9) == 0);
        for (i = 0; i < len; i++) begin
            if (spread == 0)
                xv = random_x();
            else if (spread < 0)
                xv = centre + rand_span($urandom_range(0, 3));
            else
                xv = centre + rand_span(spread);
            yv = free_y ? random_x() : ((xv * k) >>> kshift) + ofs + rand_span(noise);
            push_beat(REQ_SAMPLE, xv, yv, i == len - 1);
        end
    endtask

    task automatic queue_queries(input int count);
        int i;
        for (i = 0; i < count; i++)
            push_beat(REQ_QUERY, random_x(), random_x(), $urandom_range(0, 3) == 0);
    endtask

    // Waits until every queued beat has been taken and every result has come back.
    task automatic wait_drain();
        while (beats_sent != beats_queued || results_due.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        int  random_start;
        int  i;
        int  pick;
        bit  hold_done;
        bit  pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats. A query before any fit must report a degenerate status.
        push_beat(REQ_QUERY, 100, 0, 1'b0);
        // A batch of a single sample cannot be fitted.
        push_beat(REQ_SAMPLE, 5, 7, 1'b1);
        // Three samples at the same x have no spread; the query after it finds no fit.
        push_beat(REQ_SAMPLE, 1000, -3, 1'b0);
        push_beat(REQ_SAMPLE, 1000, 40, 1'b0);
        push_beat(REQ_SAMPLE, 1000, 900, 1'b1);
        push_beat(REQ_QUERY, -77, 0, 1'b0);
        // Full-scale samples, then queries at both ends of x; the first one also
        // carries a last mark, which a query ignores.
        push_beat(REQ_SAMPLE, Q12_MIN, Q12_MIN, 1'b0);
        push_beat(REQ_SAMPLE, Q12_MAX, Q12_MAX, 1'b0);
        push_beat(REQ_SAMPLE, 0, 0, 1'b1);
        push_beat(REQ_QUERY, Q12_MAX, random_x(), 1'b1);
        push_beat(REQ_QUERY, Q12_MIN, random_x(), 1'b0);
        // Two samples one LSB apart in x with opposite extreme y: the slope and the
        // intercept both saturate, and so do the predictions that follow.
        push_beat(REQ_SAMPLE, 1000, Q12_MIN, 1'b0);
        push_beat(REQ_SAMPLE, 1001, Q12_MAX, 1'b1);
        push_beat(REQ_QUERY, Q12_MAX, 0, 1'b0);
        push_beat(REQ_QUERY, Q12_MIN, 0, 1'b0);
        push_beat(REQ_QUERY, 0, 0, 1'b0);
        // The same on the negative side of the slope.
        push_beat(REQ_SAMPLE, -1, Q12_MAX, 1'b0);
        push_beat(REQ_SAMPLE, 0, Q12_MIN, 1'b1);
        push_beat(REQ_QUERY, 300, 0, 1'b0);
        // An exact line y = 2x, then queries on it.
        push_beat(REQ_SAMPLE, 256, 512, 1'b0);
        push_beat(REQ_SAMPLE, 512, 1024, 1'b0);
        push_beat(REQ_SAMPLE, 768, 1536, 1'b1);
        push_beat(REQ_QUERY, 1280, 0, 1'b0);
        push_beat(REQ_QUERY, -1, -1, 1'b0);
        wait_drain();

        // One batch that runs past the sample limit. The surplus samples are wild
        // outliers, so any of them being summed would spoil the fit.
        for (i = 0; i < MAX_SAMPLES; i++)
            push_beat(REQ_SAMPLE, rand_span(60000), rand_span(60000), 1'b0);
        for (i = 0; i < 6; i++)
            push_beat(REQ_SAMPLE, Q12_MIN + i, Q12_MAX - i, i == 5);
        queue_queries(3);
        wait_drain();

        // Random part: mostly well-formed batches followed by queries, mixed with
        // lone queries, single-sample batches, steep batches and batches broken up
        // by queries in the middle.
        random_start = beats_queued;
        while (beats_queued - random_start < RANDOM_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                queue_fit_batch(($urandom_range(0, 9) == 0) ? $urandom_range(13, 80)
                                                            : $urandom_range(2, 12), 1'b0);
                queue_queries($urandom_range(1, 5));
            end else if (pick < 73) begin
                queue_queries($urandom_range(1, 4));
            end else if (pick < 80) begin
                push_beat(REQ_SAMPLE, random_x(), random_x(), 1'b1);
                queue_queries(1);
            end else if (pick < 88) begin
                queue_fit_batch($urandom_range(2, 6), 1'b1);
                queue_queries($urandom_range(1, 3));
            end else begin
                for (i = $urandom_range(1, 4); i > 0; i--)
                    push_beat(REQ_SAMPLE, random_x(), random_x(), 1'b0);
                queue_queries($urandom_range(1, 3));
            end
            // With plenty still queued, hold the receiver off so that the block
            // fills up and stalls its input.
            if (!hold_done && beats_queued - random_start > 20) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            // Later on, let the sender go quiet until every result is back.
            if (!pause_done && beats_queued - random_start > 50) begin
                wait_drain();
                pause_done = 1'b1;
            end
        end

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (results_due.size() != 0)
            report_mismatch("results never delivered", results_due.size(), 0);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Safety net well beyond the slowest correct run.
    initial begin
        #(64'd20_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/lrf_pkg.sv
design/lrf_front.sv
design/lrf_div.sv
design/lrf_back.sv
design/linear_regression_fit_predict_core.sv
tb/tb_linear_regression_fit_predict_core.sv
